@@ rtl/rpmc_pkg.sv @@
// Shared types and constants for the red pixel mask and centroid block.
// Used by every module under rtl/; depends on nothing else.
package rpmc_pkg;

  // Width of the coordinate arithmetic inside the block.
  localparam int COORD_BITS = 12;

  // Fixed field widths on the stream ports.
  localparam int PIX_W   = 8;
  localparam int FIELD_W = 12;

  // The red pixel count saturates at all ones. The sums need only enough bits
  // for the largest count times the largest coordinate.
  localparam int CNT_W = 24;
  localparam int SUM_W = CNT_W + COORD_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration port.
  localparam int CFG_W     = (COORD_BITS + 1 > PIX_W) ? COORD_BITS + 1 : PIX_W;
  localparam int CFG_IDX_W = 3;

  // Stream payload widths; tdata is padded to whole bytes.
  localparam int TDATA_W = ((3 * PIX_W + 2 * FIELD_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TUSER_W = 2;

  // Queue between the classifier and the accumulator.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Divider step counter.
  localparam int STEP_W = $clog2(COORD_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MIN      = 3'd0,
    REG_RATIO_TENTHS = 3'd1,
    REG_WIN_X_LOW    = 3'd2,
    REG_WIN_X_HIGH   = 3'd3,
    REG_WIN_Y_LOW    = 3'd4,
    REG_WIN_Y_HIGH   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]      red_min;
    logic [PIX_W-1:0]      ratio_tenths;
    logic [COORD_BITS-1:0] x_low;
    logic [COORD_BITS:0]   x_high;
    logic [COORD_BITS-1:0] y_low;
    logic [COORD_BITS:0]   y_high;
  } cfg_t;

  // One classified pixel as it travels through the queue.
  typedef struct packed {
    logic [PIX_W-1:0]      red;
    logic [PIX_W-1:0]      green;
    logic [PIX_W-1:0]      blue;
    logic                  is_red;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic                  last;
  } pix_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic               is_red;
    logic [FIELD_W-1:0] cent_col;
    logic [FIELD_W-1:0] cent_row;
    logic               found;
    logic               done;
  } out_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_e;

endpackage

@@ rtl/red_pixel_mask_centroid_top.sv @@
// Red pixel mask and blob centroid, top level.
// Throughput: one pixel per cycle while the queue has room; a frame-end pixel
// holds the back end for the restoring divide, skipped if the frame had no red.
// A result is registered in the queue and then in the output register.
// Reset (rst_ni, asynchronous, active low) restores the register defaults,
// clears the sums and empties the queue; no clearing pass is needed.
module red_pixel_mask_centroid_top import rpmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,

  // Pixel input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata, low bit up: pix_red[7:0], pix_green[7:0], pix_blue[7:0],
  // pix_col[11:0], pix_row[11:0].
  input  logic [TDATA_W-1:0]     s_axis_tdata_i,
  // tlast: frame_end.
  input  logic                   s_axis_tlast_i,

  // Result output stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata, low bit up: out_red[7:0], out_green[7:0], out_blue[7:0],
  // centroid_col[11:0], centroid_row[11:0].
  output logic [TDATA_W-1:0]     m_axis_tdata_o,
  // tuser, low bit up: is_red, found.
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  // tlast: frame_done.
  output logic                   m_axis_tlast_o
);

  cfg_t       cfg_q, cfg_d;
  fifo_stat_t fifo_stat;
  pix_t       push_item, head;
  logic       push, pop;

  // Configuration registers. Writes take effect at the clock edge and the
  // datapath sees them at once, so writes must happen only while the block is
  // idle; the user is bound by this and the block itself does not enforce it.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RED_MIN:      cfg_d.red_min      = PIX_W'(cfg_wdata_i);
        REG_RATIO_TENTHS: cfg_d.ratio_tenths = PIX_W'(cfg_wdata_i);
        REG_WIN_X_LOW:    cfg_d.x_low        = COORD_BITS'(cfg_wdata_i);
        REG_WIN_X_HIGH:   cfg_d.x_high       = (COORD_BITS+1)'(cfg_wdata_i);
        REG_WIN_Y_LOW:    cfg_d.y_low        = COORD_BITS'(cfg_wdata_i);
        REG_WIN_Y_HIGH:   cfg_d.y_high       = (COORD_BITS+1)'(cfg_wdata_i);
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_min      <= PIX_W'(100);
      cfg_q.ratio_tenths <= PIX_W'(16);
      cfg_q.x_low        <= '0;
      cfg_q.x_high       <= (COORD_BITS+1)'(1) << COORD_BITS;
      cfg_q.y_low        <= '0;
      cfg_q.y_high       <= (COORD_BITS+1)'(1) << COORD_BITS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies and masks each pixel as it is accepted.
  rpmc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .cfg_i           (cfg_q),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .item_o          (push_item)
  );

  // The queue lets the front keep accepting pixels while the back end is
  // busy dividing at frame end or waiting on the output side.
  rpmc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  // The back end accumulates sums, computes the centroid and holds the
  // output register.
  rpmc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_stat_i     (fifo_stat),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ rtl/rpmc_front.sv @@
// Front end: takes pixels from the input stream, applies the window and the
// red test, and pushes the classified pixel into the queue. Uses rpmc_pkg.
module rpmc_front import rpmc_pkg::*; (
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  input  cfg_t               cfg_i,
  input  fifo_stat_t         fifo_stat_i,
  output logic               push_o,
  output pix_t               item_o
);

  logic [PIX_W-1:0]      red, green, blue;
  logic [COORD_BITS-1:0] col, row;
  logic [11:0]           red_x10;
  logic [15:0]           green_x_ratio, blue_x_ratio;
  logic                  in_win, red_hit;

  assign red   = s_axis_tdata_i[PIX_W-1:0];
  assign green = s_axis_tdata_i[2*PIX_W-1:PIX_W];
  assign blue  = s_axis_tdata_i[3*PIX_W-1:2*PIX_W];
  assign col   = COORD_BITS'(s_axis_tdata_i[3*PIX_W+FIELD_W-1:3*PIX_W]);
  assign row   = COORD_BITS'(s_axis_tdata_i[3*PIX_W+2*FIELD_W-1:3*PIX_W+FIELD_W]);

  // Ten times red against ratio times the other channels, exact in integers.
  assign red_x10       = {1'b0, red, 3'b000} + {3'b000, red, 1'b0};
  assign green_x_ratio = 16'(green) * 16'(cfg_i.ratio_tenths);
  assign blue_x_ratio  = 16'(blue) * 16'(cfg_i.ratio_tenths);

  assign in_win = (col >= cfg_i.x_low) && ({1'b0, col} < cfg_i.x_high) &&
                  (row >= cfg_i.y_low) && ({1'b0, row} < cfg_i.y_high);

  assign red_hit = in_win && (red > cfg_i.red_min) &&
                   ({4'b0000, red_x10} > green_x_ratio) &&
                   ({4'b0000, red_x10} > blue_x_ratio);

  assign s_axis_tready_o = !fifo_stat_i.full;
  assign push_o          = s_axis_tvalid_i && !fifo_stat_i.full;

  // A pixel inside the window that fails the test is blacked out.
  always_comb begin
    item_o.red    = red;
    item_o.green  = green;
    item_o.blue   = blue;
    if (in_win && !red_hit) begin
      item_o.red   = '0;
      item_o.green = '0;
      item_o.blue  = '0;
    end
    item_o.is_red = red_hit;
    item_o.col    = col;
    item_o.row    = row;
    item_o.last   = s_axis_tlast_i;
  end

endmodule

@@ rtl/rpmc_fifo.sv @@
// Short queue of classified pixels between the front end and the back end.
// Uses rpmc_pkg for the item type and depth.
module rpmc_fifo import rpmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pix_t       push_item_i,
  input  logic       pop_i,
  output pix_t       head_o,
  output fifo_stat_t stat_o
);

  pix_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;

  assign stat_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (FIFO_AW+1)'(push_i) - (FIFO_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/rpmc_back.sv @@
// Back end: accumulates red pixel sums, divides at frame end with a
// restoring divider, and drives the output register. Uses rpmc_pkg.
module rpmc_back import rpmc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fifo_stat_t         fifo_stat_i,
  input  pix_t               head_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic               m_axis_tlast_o
);

  back_state_e           state_q, state_d;
  logic [SUM_W-1:0]      col_sum_q, col_sum_d, row_sum_q, row_sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SUM_W-1:0]      col_rem_q, col_rem_d, row_rem_q, row_rem_d;
  logic [SUM_W-1:0]      dsr_q, dsr_d;
  logic [COORD_BITS-1:0] col_quot_q, col_quot_d, row_quot_q, row_quot_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  found_q, found_d;
  pix_t                  hold_q, hold_d;
  out_t                  out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  out_free, acc_en, col_ge, row_ge;
  logic [SUM_W-1:0]      col_new, row_new;
  logic [CNT_W-1:0]      cnt_new;

  assign out_free = !out_valid_q || m_axis_tready_i;

  // Sums including the head pixel; the count saturates and the sums follow it.
  assign acc_en  = head_i.is_red && (cnt_q != CNT_MAX);
  assign col_new = acc_en ? col_sum_q + SUM_W'(head_i.col) : col_sum_q;
  assign row_new = acc_en ? row_sum_q + SUM_W'(head_i.row) : row_sum_q;
  assign cnt_new = acc_en ? cnt_q + 1'b1 : cnt_q;

  assign col_ge = (col_rem_q >= dsr_q);
  assign row_ge = (row_rem_q >= dsr_q);

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    col_sum_d   = col_sum_q;
    row_sum_d   = row_sum_q;
    cnt_d       = cnt_q;
    col_rem_d   = col_rem_q;
    row_rem_d   = row_rem_q;
    dsr_d       = dsr_q;
    col_quot_d  = col_quot_q;
    row_quot_d  = row_quot_q;
    step_d      = step_q;
    found_d     = found_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          if (head_i.last) begin
            // Frame end: divide the final sums if any red, and clear them.
            pop_o      = 1'b1;
            hold_d     = head_i;
            col_rem_d  = col_new;
            row_rem_d  = row_new;
            dsr_d      = SUM_W'(cnt_new) << (COORD_BITS - 1);
            col_quot_d = '0;
            row_quot_d = '0;
            step_d     = STEP_W'(COORD_BITS - 1);
            found_d    = (cnt_new != '0);
            col_sum_d  = '0;
            row_sum_d  = '0;
            cnt_d      = '0;
            state_d    = (cnt_new != '0) ? BK_DIV : BK_EMIT;
          end else if (out_free) begin
            pop_o          = 1'b1;
            col_sum_d      = col_new;
            row_sum_d      = row_new;
            cnt_d          = cnt_new;
            out_d          = '0;
            out_d.red      = head_i.red;
            out_d.green    = head_i.green;
            out_d.blue     = head_i.blue;
            out_d.is_red   = head_i.is_red;
            out_valid_d    = 1'b1;
          end
        end
      end
      BK_DIV: begin
        // One quotient bit per cycle; the mean always fits in COORD_BITS bits.
        col_rem_d  = col_ge ? col_rem_q - dsr_q : col_rem_q;
        row_rem_d  = row_ge ? row_rem_q - dsr_q : row_rem_q;
        col_quot_d = {col_quot_q[COORD_BITS-2:0], col_ge};
        row_quot_d = {row_quot_q[COORD_BITS-2:0], row_ge};
        dsr_d      = dsr_q >> 1;
        if (step_q == '0) begin
          state_d = BK_EMIT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_d.red      = hold_q.red;
          out_d.green    = hold_q.green;
          out_d.blue     = hold_q.blue;
          out_d.is_red   = hold_q.is_red;
          out_d.cent_col = FIELD_W'(col_quot_q);
          out_d.cent_row = FIELD_W'(row_quot_q);
          out_d.found    = found_q;
          out_d.done     = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_sum_q   <= col_sum_d;
      row_sum_q   <= row_sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_rem_q  <= col_rem_d;
    row_rem_q  <= row_rem_d;
    dsr_q      <= dsr_d;
    col_quot_q <= col_quot_d;
    row_quot_q <= row_quot_d;
    step_q     <= step_d;
    found_q    <= found_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_W'({out_q.cent_row, out_q.cent_col,
                                     out_q.blue, out_q.green, out_q.red});
  assign m_axis_tuser_o  = {out_q.found, out_q.is_red};
  assign m_axis_tlast_o  = out_q.done;

endmodule
